// File: rtl/aabb_pkg.sv
// Package for the collision table block: types, command and status codes.
// No dependencies.
package aabb_pkg;

  localparam int unsigned SlotsDef = 64;

  localparam logic [2:0] CmdAdd    = 3'd0;
  localparam logic [2:0] CmdSetRect = 3'd1;
  localparam logic [2:0] CmdMarkDel = 3'd2;
  localparam logic [2:0] CmdSweep  = 3'd3;
  localparam logic [2:0] CmdClear  = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         slot;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [14:0]        width;
    logic [14:0]        height;
    logic [3:0]         kind;
    logic               has_listener;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot_out;
    logic [63:0] hit_mask;
    logic        last;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic       load;      // capture item, run single commands
    logic       purge;     // free slots marked for deletion
    logic       row_emit;  // emit a sweep result for row_idx
    logic [5:0] row_idx;
    logic       row_last;
  } ctl_t;

endpackage

// File: rtl/aabb_datapath.sv
// Datapath: entry table, rectangle registers and one-row overlap compare.
// Depends on aabb_pkg.
module aabb_datapath import aabb_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  ctl_t      ctl_i,
  input  logic      cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output logic      res_valid_o,
  output out_item_t res_o
);
  localparam int unsigned Iw = $clog2(Slots);

  logic [63:0] pair_q [4];
  logic [Slots-1:0] valid_q, del_q;
  logic signed [15:0] rx_q [Slots];
  logic signed [15:0] ry_q [Slots];
  logic [14:0] rw_q [Slots];
  logic [14:0] rh_q [Slots];
  logic [3:0]  kind_q [Slots];
  logic [Slots-1:0] lis_q;

  // lowest free slot
  logic [Iw-1:0] free_idx;
  logic          free_found;
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = Iw'(i);
        free_found = 1'b1;
      end
    end
  end

  logic          slot_ok;
  logic [Iw-1:0] sidx;
  assign slot_ok = ({26'd0, item_i.slot} < 32'(Slots)) && valid_q[item_i.slot[Iw-1:0]];
  assign sidx = item_i.slot[Iw-1:0];

  // row compare against all slots
  logic [Iw-1:0] ri;
  logic [63:0]   row_mask;
  logic [15:0]   pair_row;
  assign ri = ctl_i.row_idx[Iw-1:0];
  always_comb begin
    logic signed [17:0] xi, yi, xie, yie, xk, yk, xke, yke;
    pair_row = pair_q[kind_q[ri][3:2]][{kind_q[ri][1:0], 4'd0} +: 16];
    xi = 18'(rx_q[ri]);
    yi = 18'(ry_q[ri]);
    xie = xi + $signed({3'd0, rw_q[ri]});
    yie = yi + $signed({3'd0, rh_q[ri]});
    row_mask = '0;
    for (int k = 0; k < Slots; k++) begin
      xk = 18'(rx_q[k]);
      yk = 18'(ry_q[k]);
      xke = xk + $signed({3'd0, rw_q[k]});
      yke = yk + $signed({3'd0, rh_q[k]});
      row_mask[k] = (k != int'(ri)) && valid_q[k] && (xi < xke) && (xie > xk) &&
                    (yi < yke) && (yie > yk) && pair_row[kind_q[k]];
    end
    if (!(valid_q[ri] && lis_q[ri])) row_mask = '0;
  end

  // next result: sweep row or single-command answer
  logic      res_fire;
  out_item_t res_d;
  assign res_fire = ctl_i.row_emit || (ctl_i.load && (item_i.cmd <= CmdClear) &&
                                       (item_i.cmd != CmdSweep));
  always_comb begin
    res_d = '{status: StOk, slot_out: 6'd0, hit_mask: 64'd0, last: 1'b1};
    if (ctl_i.row_emit) begin
      res_d.status = valid_q[ri] ? StOk : StEmpty;
      res_d.slot_out = 6'(ri);
      res_d.hit_mask = row_mask;
      res_d.last = ctl_i.row_last;
    end else begin
      case (item_i.cmd)
        CmdAdd: begin
          if (free_found) res_d.slot_out = 6'(free_idx);
          else res_d.status = StFull;
        end
        CmdSetRect, CmdMarkDel: if (!slot_ok) res_d.status = StEmpty;
        default: ;
      endcase
    end
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) pair_q[r] <= '0;
    end else if (cfg_we_i) begin
      pair_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // table control state and results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      del_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= res_fire;
      if (ctl_i.purge) begin
        valid_q <= valid_q & ~del_q;
        del_q <= '0;
      end
      if (ctl_i.load) begin
        case (item_i.cmd)
          CmdAdd: begin
            if (free_found) begin
              valid_q[free_idx] <= 1'b1;
              del_q[free_idx] <= 1'b0;
            end
          end
          CmdMarkDel: begin
            if (slot_ok) del_q[sidx] <= 1'b1;
          end
          CmdClear: begin
            valid_q <= '0;
            del_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // payload and entry contents
  always_ff @(posedge clk_i) begin
    if (res_fire) res_o <= res_d;
    if (ctl_i.load) begin
      case (item_i.cmd)
        CmdAdd: begin
          if (free_found) begin
            rx_q[free_idx] <= item_i.pos_x;
            ry_q[free_idx] <= item_i.pos_y;
            rw_q[free_idx] <= item_i.width;
            rh_q[free_idx] <= item_i.height;
            kind_q[free_idx] <= item_i.kind;
            lis_q[free_idx] <= item_i.has_listener;
          end
        end
        CmdSetRect: begin
          if (slot_ok) begin
            rx_q[sidx] <= item_i.pos_x;
            ry_q[sidx] <= item_i.pos_y;
            rw_q[sidx] <= item_i.width;
            rh_q[sidx] <= item_i.height;
          end
        end
        default: ;
      endcase
    end
  end

  // never both single command and sweep row in one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ctl_i.load && ctl_i.row_emit))
    else $error("load during sweep row");
  // a purge leaves no marked slot
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_i.purge |=> del_q == '0)
    else $error("marks survive purge");
  // marked slots are always valid
  assert property (@(posedge clk_i) disable iff (!rst_ni) (del_q & ~valid_q) == '0)
    else $error("mark on empty slot");
endmodule

// File: rtl/aabb_ctrl.sv
// Controller FSM: accepts commands, sequences the sweep rows.
// Depends on aabb_pkg.
module aabb_ctrl import aabb_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] cmd_i,
  output logic       busy_o,
  output ctl_t       ctl_o
);
  localparam logic [1:0] SIdle = 2'd0, SPurge = 2'd1, SRows = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] row_q, row_d;
  logic acc;

  assign acc = start_i && !busy_o;
  assign busy_o = state_q != SIdle;

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    ctl_o = '0;
    ctl_o.row_idx = row_q;
    ctl_o.row_last = row_q == 6'(Slots - 1);
    case (state_q)
      SIdle: begin
        if (acc) begin
          ctl_o.load = 1'b1;
          if (cmd_i == CmdSweep) state_d = SPurge;
        end
      end
      SPurge: begin
        ctl_o.purge = 1'b1;
        row_d = '0;
        state_d = SRows;
      end
      SRows: begin
        ctl_o.row_emit = 1'b1;
        row_d = row_q + 6'd1;
        if (ctl_o.row_last) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      row_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SPurge) |=> (state_q == SRows && row_q == 6'd0))
    else $error("sweep did not start at row 0");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cmd_i == CmdSweep) |=> state_q == SPurge)
    else $error("sweep not started");
endmodule

// File: rtl/aabb_collision_table_unit.sv
// Top level of the collision table: controller plus datapath.
// Single commands: result registered and shown in the cycle after accept, next accept in that cycle.
// Sweep: busy through the purge state and then one row state per slot; each row's result is registered.
// One row is compared against every slot per cycle by the datapath compare array.
// Reset clears the valid and delete marks and the pair registers; no clearing pass.
// Results cannot be stalled; they are shown for one cycle with res_valid_o.
module aabb_collision_table_unit import aabb_pkg::*; #(
  parameter int unsigned Slots = SlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        res_valid_o,
  output out_item_t   res_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);
  ctl_t ctl;

  assign cfg_ready_o = 1'b1;

  aabb_ctrl #(.Slots(Slots)) u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(item_i.cmd), .busy_o(busy), .ctl_o(ctl)
  );

  aabb_datapath #(.Slots(Slots)) u_dp (
    .clk_i, .rst_ni, .item_i, .ctl_i(ctl),
    .cfg_we_i(cfg_valid_i), .cfg_idx_i, .cfg_data_i,
    .res_valid_o, .res_o
  );
endmodule
